/* rtl/core/fbd_pkg.sv */
// Shared types and constants for the four-button debounce / long-press unit.
// No dependencies.
package fbd_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int EVENT_W     = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [EVENT_W-1:0]   event_code_t;

	// Configuration register indexes
	localparam cfg_index_t REG_DEBOUNCE   = 2'd0;
	localparam cfg_index_t REG_LONG_PRESS = 2'd1;

	localparam cfg_data_t DEBOUNCE_RESET   = 16'd50;
	localparam cfg_data_t LONG_PRESS_RESET = 16'd1000;

	// Per-button event kind
	typedef logic [1:0] ev_kind_t;
	localparam ev_kind_t KIND_NONE  = 2'd0;
	localparam ev_kind_t KIND_SHORT = 2'd1;
	localparam ev_kind_t KIND_LONG  = 2'd2;

	// Event codes
	localparam event_code_t EV_NONE        = 4'd0;
	localparam event_code_t EV_UP          = 4'd1;
	localparam event_code_t EV_UP_LONG     = 4'd2;
	localparam event_code_t EV_DOWN        = 4'd3;
	localparam event_code_t EV_DOWN_LONG   = 4'd4;
	localparam event_code_t EV_SELECT      = 4'd5;
	localparam event_code_t EV_SELECT_LONG = 4'd6;
	localparam event_code_t EV_MODE        = 4'd7;
	localparam event_code_t EV_MODE_LONG   = 4'd8;

	// Scan order: up, down, select, mode
	localparam event_code_t SHORT_CODE [NUM_BUTTONS] =
		'{EV_UP, EV_DOWN, EV_SELECT, EV_MODE};
	localparam event_code_t LONG_CODE [NUM_BUTTONS] =
		'{EV_UP_LONG, EV_DOWN_LONG, EV_SELECT_LONG, EV_MODE_LONG};

endpackage

/* rtl/core/four_button_debounce_long_press_unit.sv */
// Four-button debouncer with short-press and long-press event reporting.
// Depends on fbd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one transfer per sampling tick, carrying
//   the raw active-low levels of up, down, select and mode (raw_levels bits
//   0..3) and the free-running time stamp now_ticks.
//   Output channel (out_valid/out_ready): one transfer per input item carrying
//   event_code (0 none, odd = short press, even = long press, by button).
//   Config port: cfg_we/cfg_index/cfg_data, index 0 debounce_ticks, index 1
//   long_press_ticks; other indexes are ignored. Write only while idle.
// Pipeline and throughput:
//   An item is registered in the input register at its input transfer, is
//   evaluated against the per-button state and lands in the output register
//   once that register is empty or being emptied. One item per cycle is
//   sustained while out_ready stays high; the input register and the output
//   register each hold one item.
// Reset:
//   All buttons read released, timers zero, thresholds 50 and 1000 ticks.
// Stall:
//   When out_ready is low the result holds, the input register fills and
//   in_ready drops; no item is lost or duplicated.
module four_button_debounce_long_press_unit #(
	parameter int TIME_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                raw_levels,
	input  logic [TIME_BITS-1:0]      now_ticks,
	output logic                      out_valid,
	input  logic                      out_ready,
	output fbd_pkg::event_code_t      event_code,
	input  logic                      cfg_we,
	input  fbd_pkg::cfg_index_t       cfg_index,
	input  fbd_pkg::cfg_data_t        cfg_data
);
	import fbd_pkg::*;

	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	// Configuration
	cfg_data_t debounce_q;
	cfg_data_t long_press_q;

	// Input register
	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] raw_s1;
	logic [TIME_BITS-1:0]   now_s1;

	// Per-button state
	logic [NUM_BUTTONS-1:0] raw_prev_q;
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] long_seen_q;
	logic [TIME_BITS-1:0]   change_time_q [NUM_BUTTONS];
	logic [TIME_BITS-1:0]   press_time_q  [NUM_BUTTONS];

	// Output register
	logic        out_valid_q;
	event_code_t event_code_q;

	logic advance;

	// Next-state candidates per button
	logic [NUM_BUTTONS-1:0] stable_n;
	logic [NUM_BUTTONS-1:0] long_n;
	logic [TIME_BITS-1:0]   change_n [NUM_BUTTONS];
	logic [TIME_BITS-1:0]   press_n  [NUM_BUTTONS];
	ev_kind_t               kind     [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] upd;
	event_code_t            code_n;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign event_code = event_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_levels;
			now_s1 <= now_ticks;
		end
	end

	genvar b;
	generate
		for (b = 0; b < NUM_BUTTONS; b++) begin : g_btn
			logic                 lvl;
			logic                 chg;
			logic [TIME_BITS-1:0] since_change;
			logic [TIME_BITS-1:0] since_press;
			logic                 settled;
			logic                 accept_lvl;
			logic                 st1;
			logic                 lg1;
			logic                 held_long;

			assign lvl          = raw_s1[b];
			assign chg          = lvl != raw_prev_q[b];
			assign change_n[b]  = chg ? now_s1 : change_time_q[b];
			// Modulo time difference; a fresh change gives zero, so it never settles
			assign since_change = now_s1 - change_n[b];
			assign settled      = CMP_W'(since_change) > CMP_W'(debounce_q);
			assign accept_lvl   = settled && (lvl != stable_q[b]);
			assign st1          = accept_lvl ? lvl : stable_q[b];
			assign press_n[b]   = (accept_lvl && !lvl) ? now_s1 : press_time_q[b];
			assign lg1          = accept_lvl ? 1'b0 : long_seen_q[b];
			assign since_press  = now_s1 - press_n[b];
			assign held_long    = !st1 && !lg1 &&
			                      (CMP_W'(since_press) > CMP_W'(long_press_q));
			assign stable_n[b]  = st1;
			assign long_n[b]    = lg1 || held_long;

			always_comb begin
				if (held_long) begin
					kind[b] = KIND_LONG;
				end else if (accept_lvl && lvl && !long_seen_q[b]) begin
					kind[b] = KIND_SHORT;
				end else begin
					kind[b] = KIND_NONE;
				end
			end
		end
	endgenerate

	// Scan in fixed order; stop updating after the first event
	always_comb begin
		logic hit;
		hit    = 1'b0;
		code_n = EV_NONE;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			upd[i] = !hit;
			if (!hit) begin
				case (kind[i])
					KIND_SHORT: begin
						code_n = SHORT_CODE[i];
						hit    = 1'b1;
					end
					KIND_LONG: begin
						code_n = LONG_CODE[i];
						hit    = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q  <= '1;
			stable_q    <= '1;
			long_seen_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				change_time_q[i] <= '0;
				press_time_q[i]  <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (upd[i]) begin
					raw_prev_q[i]    <= raw_s1[i];
					stable_q[i]      <= stable_n[i];
					long_seen_q[i]   <= long_n[i];
					change_time_q[i] <= change_n[i];
					press_time_q[i]  <= press_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_code_q <= code_n;
		end
	end

	// An empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	// Debounced state moves only when an item is evaluated
	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(stable_q) && $stable(long_seen_q)))
		else $error("button state changed without an item");

	generate
		for (b = 0; b < NUM_BUTTONS; b++) begin : g_chk
			// A reported long press is only ever flagged on a held button
			a_long_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
				long_seen_q[b] |-> !stable_q[b])
				else $error("long press flagged on a released button");

			// A long-press event marks the button as already reported
			a_long_marks_seen: assert property (@(posedge clk) disable iff (!arst_n)
				(advance && code_n == LONG_CODE[b]) |=> long_seen_q[b])
				else $error("long press reported without marking the button");
		end
	endgenerate

endmodule

/* tb/four_button_debounce_long_press_unit_tb.sv */
// Testbench for four_button_debounce_long_press_unit: directed and random button traffic
// checked against a cycle-free behavioral predictor of the debounce / press-event logic.
// Depends on fbd_pkg and the unit itself.
`timescale 1ns / 100ps

module four_button_debounce_long_press_unit_tb;
	import fbd_pkg::*;

	localparam int TIME_BITS = 16;
	localparam int DRAIN_CYCLES = 6;
	localparam cfg_index_t REG_SPARE_A = 2'd2;
	localparam cfg_index_t REG_SPARE_B = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [3:0]           raw_levels;
	logic [TIME_BITS-1:0] now_ticks;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	event_code_t          event_code;
	logic                 cfg_we;
	cfg_index_t           cfg_index;
	cfg_data_t            cfg_data;

	// predictor copy of thresholds and per-button state
	cfg_data_t            deb_ticks;
	cfg_data_t            lp_ticks;
	logic                 last_raw    [NUM_BUTTONS];
	logic                 settled     [NUM_BUTTONS];
	logic [TIME_BITS-1:0] edge_time   [NUM_BUTTONS];
	logic [TIME_BITS-1:0] press_start [NUM_BUTTONS];
	logic                 long_done   [NUM_BUTTONS];

	event_code_t pending_events[$];
	int          fail_count;
	int          send_gap_pct;
	int          recv_stall_pct;

	four_button_debounce_long_press_unit #(
		.TIME_BITS(TIME_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_levels(raw_levels),
		.now_ticks (now_ticks),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_code(event_code),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[four_button_debounce_long_press_unit] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_button_state();
		deb_ticks = DEBOUNCE_RESET;
		lp_ticks  = LONG_PRESS_RESET;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			last_raw[b]    = 1'b1;
			settled[b]     = 1'b1;
			edge_time[b]   = '0;
			press_start[b] = '0;
			long_done[b]   = 1'b0;
		end
	endtask

	// Scan up, down, select, mode; stop at the first button that reports.
	function automatic event_code_t scan_sample(input logic [3:0] lv,
			input logic [TIME_BITS-1:0] t);
		event_code_t          code;
		ev_kind_t             kind;
		logic [TIME_BITS-1:0] elapsed;
		logic                 lvl;
		code = EV_NONE;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			kind = KIND_NONE;
			lvl  = lv[b];
			if (lvl != last_raw[b])
				edge_time[b] = t;
			elapsed = t - edge_time[b];
			if (elapsed > deb_ticks && lvl != settled[b]) begin
				settled[b] = lvl;
				if (lvl == 1'b0) begin
					press_start[b] = t;
				end else if (!long_done[b]) begin
					kind = KIND_SHORT;
				end
				long_done[b] = 1'b0;
			end
			elapsed = t - press_start[b];
			if (settled[b] == 1'b0 && !long_done[b] && elapsed > lp_ticks) begin
				long_done[b] = 1'b1;
				kind = KIND_LONG;
			end
			last_raw[b] = lvl;
			if (kind == KIND_SHORT) begin
				code = SHORT_CODE[b];
				break;
			end else if (kind == KIND_LONG) begin
				code = LONG_CODE[b];
				break;
			end
		end
		return code;
	endfunction

	task automatic send_sample(input logic [3:0] lv, input logic [TIME_BITS-1:0] t);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_levels <= lv;
		now_ticks  <= t;
		do
			@(posedge clk);
		while (!in_ready);
		pending_events.push_back(scan_sample(lv, t));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers change only with nothing in flight; spare indexes get junk.
	task automatic program_thresholds(input cfg_data_t deb, input cfg_data_t lp);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data  <= deb;
		@(posedge clk);
		deb_ticks = deb;
		cfg_index <= REG_LONG_PRESS;
		cfg_data  <= lp;
		@(posedge clk);
		lp_ticks = lp;
		cfg_index <= REG_SPARE_A;
		cfg_data  <= cfg_data_t'($urandom);
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		cfg_data  <= cfg_data_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reset thresholds: strict debounce edge, long press then silent release,
	// short press across the time wrap.
	task automatic test_directed_presses();
		send_sample(4'hF, 16'd100);
		send_sample(4'hE, 16'd200);
		send_sample(4'hE, 16'd250);
		send_sample(4'hE, 16'd251);
		send_sample(4'hE, 16'd1251);
		send_sample(4'hE, 16'd1252);
		send_sample(4'hF, 16'd1300);
		send_sample(4'hF, 16'd1351);
		send_sample(4'hB, 16'd65535);
		send_sample(4'hB, 16'd50);
		send_sample(4'hF, 16'd60);
		send_sample(4'hF, 16'd111);
	endtask

	// All buttons at once: each event holds back the later buttons for a sample.
	task automatic test_skipped_buttons();
		program_thresholds(16'd5, 16'd40);
		send_sample(4'h0, 16'd0);
		send_sample(4'h0, 16'd6);
		send_sample(4'h0, 16'd47);
		send_sample(4'h0, 16'd48);
		send_sample(4'h0, 16'd49);
		send_sample(4'h0, 16'd50);
		send_sample(4'hF, 16'd60);
		send_sample(4'hF, 16'd66);
		send_sample(4'h0, 16'd70);
		send_sample(4'h0, 16'd76);
		send_sample(4'hF, 16'd80);
		send_sample(4'hF, 16'd86);
		send_sample(4'hF, 16'd87);
		send_sample(4'hF, 16'd88);
		send_sample(4'hF, 16'd89);
	endtask

	// Held presses of random length with bounce and occasional time jumps.
	task automatic test_random_traffic(input int n_items);
		logic [3:0]           held;
		logic [3:0]           lv;
		logic [TIME_BITS-1:0] t;
		int                   span;
		int                   step_max;
		held = 4'hF;
		t = TIME_BITS'($urandom);
		span = (lp_ticks > deb_ticks) ? int'(lp_ticks) : int'(deb_ticks);
		step_max = span / 16 + 1;
		for (int i = 0; i < n_items; i++) begin
			for (int b = 0; b < NUM_BUTTONS; b++)
				if ($urandom_range(0, 9) == 0)
					held[b] = ~held[b];
			lv = held;
			if ($urandom_range(0, 7) == 0)
				lv[$urandom_range(0, 3)] ^= 1'b1;
			if ($urandom_range(0, 49) == 0)
				t = TIME_BITS'($urandom);
			else
				t = t + TIME_BITS'($urandom_range(0, step_max));
			send_sample(lv, t);
		end
	endtask

	task automatic test_threshold_extremes();
		program_thresholds(16'd0, 16'd0);
		test_random_traffic(150);
		program_thresholds(16'hFFFF, 16'hFFFF);
		test_random_traffic(40);
		program_thresholds(16'd0, 16'hFFFF);
		test_random_traffic(80);
		program_thresholds(16'hFFFF, 16'd0);
		test_random_traffic(40);
	endtask

	// Check each output transfer, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event_code %0d", event_code));
			end else begin
				if (event_code !== pending_events[0])
					report_mismatch($sformatf("event_code got %0d expected %0d",
						event_code, pending_events[0]));
				void'(pending_events.pop_front());
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		fail_count     = 0;
		send_gap_pct   = 12;
		recv_stall_pct = 49;
		clear_button_state();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		raw_levels <= 4'hF;
		now_ticks  <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_DEBOUNCE;
		cfg_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_presses();
		test_skipped_buttons();
		program_thresholds(DEBOUNCE_RESET, LONG_PRESS_RESET);
		test_random_traffic(550);

		wait_drained();
		send_gap_pct   = 49;
		recv_stall_pct = 12;
		test_threshold_extremes();
		program_thresholds(cfg_data_t'($urandom_range(0, 200)),
			cfg_data_t'($urandom_range(0, 3000)));
		test_random_traffic(400);

		wait_drained();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		program_thresholds(cfg_data_t'($urandom_range(0, 1000)),
			cfg_data_t'($urandom_range(0, 20000)));
		test_random_traffic(500);

		wait_drained();
		if (pending_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
		if (fail_count == 0) begin
			$display("[four_button_debounce_long_press_unit] OK");
		end else begin
			$display("[four_button_debounce_long_press_unit] ERROR");
		end
		$finish;
	end

endmodule

/* four_button_debounce_long_press_unit.f */
rtl/core/fbd_pkg.sv
rtl/core/four_button_debounce_long_press_unit.sv
tb/four_button_debounce_long_press_unit_tb.sv
